// File: sv/bfw_pkg.sv
package bfw_pkg;

  // Defaults for the top-level parameters
  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int DIM_BITS_DEF     = 12;

  // BMP header layout
  localparam int HDR_BYTES      = 54;
  localparam int HDR_OFS_W      = 6;
  localparam int WIDTH_LAST_OFS = 21;
  localparam int HEIGHT_LAST_OFS = 25;

  // Payload widths
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 20;
  localparam int WORD_W   = 24;
  localparam int ORG_ROW_W = 9;
  localparam int ORG_COL_W = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ORIGIN_ROW    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ORIGIN_COLUMN = cfg_idx_t'(1);

endpackage

// File: sv/bfw_if.sv
interface bfw_in_if;
  import bfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink (input valid, input file_byte, input first_byte, output ready);
endinterface

interface bfw_out_if;
  import bfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic [WORD_W-1:0] pixel_word;
  logic              off_screen;
  logic              last_pixel;

  modport source (output valid, output pixel_address, output pixel_word,
                  output off_screen, output last_pixel, input ready);
  modport sink (input valid, input pixel_address, input pixel_word,
                input off_screen, input last_pixel, output ready);
endinterface

interface bfw_cfg_if;
  import bfw_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_idx_t              reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: sv/bmp24_to_framebuffer_writer.sv
// Channel  | Dir | Payload                                           | Beat when
// ---------+-----+---------------------------------------------------+------------------
// in_bus   | in  | file_byte[7:0], first_byte                        | valid && ready
// out_bus  | out | pixel_address[19:0], pixel_word[23:0],            | valid && ready
//          |     | off_screen, last_pixel                            |
// cfg_bus  | in  | reg_index (0 origin_row, 1 origin_column), wr_data| valid && ready
//
// One file byte per cycle sustained while out_bus accepts; a pixel write leaves
// after its red byte is taken, via the parse/row-column and multiply-add stages.
// rst_n is synchronous, active low; after reset bytes are dropped until a
// beat with first_byte set. A stall on out_bus holds both stages; in_bus
// stays ready while either stage has room. cfg_bus is always ready.
module bmp24_to_framebuffer_writer #(
  parameter int FRAME_WIDTH  = bfw_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bfw_pkg::FRAME_HEIGHT_DEF,
  parameter int DIM_BITS     = bfw_pkg::DIM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfw_in_if.sink    in_bus,
  bfw_out_if.source out_bus,
  bfw_cfg_if.sink   cfg_bus
);
  import bfw_pkg::*;

  // Frame row/column need one bit over the wider of origin and image extent.
  localparam int ROW_W = ((DIM_BITS > ORG_ROW_W) ? DIM_BITS : ORG_ROW_W) + 1;
  localparam int COL_W = ((DIM_BITS > ORG_COL_W) ? DIM_BITS : ORG_COL_W) + 1;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  // Configuration
  logic [ORG_ROW_W-1:0] origin_row_r;
  logic [ORG_COL_W-1:0] origin_col_r;

  // Parse state; the header shifter keeps the last three header bytes.
  logic [HDR_OFS_W-1:0] hdr_ofs_r, hdr_ofs_nxt;
  logic [23:0]          hdr_shift_r, hdr_shift_nxt;
  logic [DIM_BITS-1:0]  img_w_r, img_w_nxt;
  logic [DIM_BITS-1:0]  img_h_r, img_h_nxt;
  logic [DIM_BITS-1:0]  col_cnt_r, col_cnt_nxt;
  logic [DIM_BITS-1:0]  row_cnt_r, row_cnt_nxt;
  logic [1:0]           pix_byte_r, pix_byte_nxt;
  logic [15:0]          part_bg_r, part_bg_nxt;
  logic [1:0]           pad_left_r, pad_left_nxt;
  logic                 finished_r, finished_nxt;

  // Stage 1: frame position and pixel
  logic                 s1_valid_r;
  logic [ROW_W-1:0]     s1_row_r, s1_row_nxt;
  logic [COL_W-1:0]     s1_col_r, s1_col_nxt;
  logic [WORD_W-1:0]    s1_word_r, s1_word_nxt;
  logic                 s1_last_r, s1_last_nxt;
  logic                 emit;

  // Stage 2: output register
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [WORD_W-1:0]    out_word_r;
  logic                 out_off_r;
  logic                 out_last_r;

  logic adv2, adv1, in_beat;
  logic [31:0]          raw_dim;
  logic [DIM_BITS-1:0]  sat_dim;

  assign adv2    = !out_valid_r || out_bus.ready;
  assign adv1    = !s1_valid_r || adv2;
  assign in_bus.ready = adv1;
  assign in_beat = in_bus.valid && adv1;
  assign cfg_bus.ready = 1'b1;

  // Dimension word as it stands once its top byte arrives; negative reads
  // as zero, oversize clamps to the counter limit.
  assign raw_dim = {in_bus.file_byte, hdr_shift_r};
  always_comb begin
    if (raw_dim[31]) begin
      sat_dim = '0;
    end else if (|raw_dim[30:DIM_BITS]) begin
      sat_dim = DIM_MAX;
    end else begin
      sat_dim = raw_dim[DIM_BITS-1:0];
    end
  end

  // Byte parser
  always_comb begin
    hdr_ofs_nxt   = hdr_ofs_r;
    hdr_shift_nxt = hdr_shift_r;
    img_w_nxt     = img_w_r;
    img_h_nxt     = img_h_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    pix_byte_nxt  = pix_byte_r;
    part_bg_nxt   = part_bg_r;
    pad_left_nxt  = pad_left_r;
    finished_nxt  = finished_r;
    emit          = 1'b0;
    s1_row_nxt    = s1_row_r;
    s1_col_nxt    = s1_col_r;
    s1_word_nxt   = s1_word_r;
    s1_last_nxt   = s1_last_r;

    // Restart the parse on a file's first byte.
    if (in_bus.first_byte) begin
      hdr_ofs_nxt   = '0;
      hdr_shift_nxt = '0;
      img_w_nxt     = '0;
      img_h_nxt     = '0;
      col_cnt_nxt   = '0;
      row_cnt_nxt   = '0;
      pix_byte_nxt  = '0;
      part_bg_nxt   = '0;
      pad_left_nxt  = '0;
      finished_nxt  = 1'b0;
    end

    if (!finished_nxt) begin
      if (hdr_ofs_nxt < HDR_OFS_W'(HDR_BYTES)) begin
        hdr_shift_nxt = {in_bus.file_byte, hdr_shift_nxt[23:8]};
        if (hdr_ofs_nxt == HDR_OFS_W'(WIDTH_LAST_OFS)) begin
          img_w_nxt = sat_dim;
        end else if (hdr_ofs_nxt == HDR_OFS_W'(HEIGHT_LAST_OFS)) begin
          img_h_nxt = sat_dim;
        end
        hdr_ofs_nxt = hdr_ofs_nxt + 1'b1;
        // Empty image: nothing to write.
        if (hdr_ofs_nxt == HDR_OFS_W'(HDR_BYTES) &&
            (img_w_nxt == '0 || img_h_nxt == '0)) begin
          finished_nxt = 1'b1;
        end
      end else if (pad_left_nxt != '0) begin
        pad_left_nxt = pad_left_nxt - 1'b1;
      end else if (pix_byte_nxt < 2'd2) begin
        part_bg_nxt  = {part_bg_nxt[7:0], in_bus.file_byte};
        pix_byte_nxt = pix_byte_nxt + 1'b1;
      end else begin
        // Red byte completes the pixel; file rows run bottom-up.
        emit         = 1'b1;
        pix_byte_nxt = '0;
        s1_row_nxt   = ROW_W'(origin_row_r) + ROW_W'(img_h_nxt) - ROW_W'(row_cnt_nxt)
                       - ROW_W'(1);
        s1_col_nxt   = COL_W'(origin_col_r) + COL_W'(col_cnt_nxt);
        s1_word_nxt  = {part_bg_nxt, in_bus.file_byte};
        s1_last_nxt  = ((DIM_BITS+1)'(row_cnt_nxt) + 1'b1 == (DIM_BITS+1)'(img_h_nxt)) &&
                       ((DIM_BITS+1)'(col_cnt_nxt) + 1'b1 == (DIM_BITS+1)'(img_w_nxt));
        if ((DIM_BITS+1)'(col_cnt_nxt) + 1'b1 >= (DIM_BITS+1)'(img_w_nxt)) begin
          col_cnt_nxt  = '0;
          row_cnt_nxt  = row_cnt_nxt + 1'b1;
          pad_left_nxt = img_w_nxt[1:0];
        end else begin
          col_cnt_nxt = col_cnt_nxt + 1'b1;
        end
        if (s1_last_nxt) begin
          finished_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_row_r <= '0;
      origin_col_r <= '0;
      hdr_ofs_r    <= '0;
      hdr_shift_r  <= '0;
      img_w_r      <= '0;
      img_h_r      <= '0;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      pix_byte_r   <= '0;
      part_bg_r    <= '0;
      pad_left_r   <= '0;
      finished_r   <= 1'b1;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.reg_index)
          REG_ORIGIN_ROW:    origin_row_r <= cfg_bus.wr_data[ORG_ROW_W-1:0];
          REG_ORIGIN_COLUMN: origin_col_r <= cfg_bus.wr_data[ORG_COL_W-1:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        hdr_ofs_r   <= hdr_ofs_nxt;
        hdr_shift_r <= hdr_shift_nxt;
        img_w_r     <= img_w_nxt;
        img_h_r     <= img_h_nxt;
        col_cnt_r   <= col_cnt_nxt;
        row_cnt_r   <= row_cnt_nxt;
        pix_byte_r  <= pix_byte_nxt;
        part_bg_r   <= part_bg_nxt;
        pad_left_r  <= pad_left_nxt;
        finished_r  <= finished_nxt;
      end
      if (adv1) begin
        s1_valid_r <= in_beat && emit;
      end
      if (adv2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers: load on advance, no reset.
  always_ff @(posedge clk) begin
    if (in_beat && emit) begin
      s1_row_r  <= s1_row_nxt;
      s1_col_r  <= s1_col_nxt;
      s1_word_r <= s1_word_nxt;
      s1_last_r <= s1_last_nxt;
    end
    if (adv2 && s1_valid_r) begin
      // Word index wraps at the address width.
      out_addr_r <= ADDR_W'(s1_row_r) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(s1_col_r);
      out_word_r <= s1_word_r;
      out_off_r  <= (32'(s1_row_r) >= 32'(FRAME_HEIGHT)) ||
                    (32'(s1_col_r) >= 32'(FRAME_WIDTH));
      out_last_r <= s1_last_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.pixel_address = out_addr_r;
  assign out_bus.pixel_word    = out_word_r;
  assign out_bus.off_screen    = out_off_r;
  assign out_bus.last_pixel    = out_last_r;

endmodule

// File: dv/bmp24_to_framebuffer_writer_tb.sv
module bmp24_to_framebuffer_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfw_pkg::*;

  localparam int DIM_MAX      = (1 << DIM_BITS_DEF) - 1;
  localparam int DRAIN_CYCLES = 6;      // two pipeline stages plus margin
  localparam int LONG_HOLD    = 150;    // receiver back-pressure stretch, in cycles
  localparam int MAX_BODY     = 300;    // cap on pixel bytes of one file
  localparam int RANDOM_BYTES = 750;
  localparam int QUIET_BYTES  = 250;    // closing stretch without idling
  localparam int END_WAIT     = 2000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              off;
    logic              last;
  } fb_write_t;

  // Clamp a 32-bit header dimension: negative reads as zero, large values
  // saturate at the largest count the block can hold.
  function automatic logic [DIM_BITS_DEF-1:0] clamp_dim(input logic [31:0] raw);
    if (raw[31]) return '0;
    if (raw > DIM_MAX) return DIM_BITS_DEF'(DIM_MAX);
    return raw[DIM_BITS_DEF-1:0];
  endfunction

  class bmp_pixel_scoreboard;
    fb_write_t                 pending_writes[$];
    bit [ORG_ROW_W-1:0]        origin_row;
    bit [ORG_COL_W-1:0]        origin_col;
    bit [HDR_OFS_W-1:0]        hdr_pos;
    bit [DIM_BITS_DEF-1:0]     img_w, img_h, col_pos, file_row;
    bit [1:0]                  bgr_phase;
    bit [15:0]                 blue_green;
    bit [1:0]                  pad_left;
    bit                        image_done = 1'b1;
    bit [31:0]                 hdr_shift;
    int unsigned               fail_count, bytes_taken, writes_checked;
    int unsigned               off_screen_seen, images_done, reg_writes;

    function void set_origin(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_ORIGIN_ROW:    origin_row = data[ORG_ROW_W-1:0];
        REG_ORIGIN_COLUMN: origin_col = data[ORG_COL_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the parse by one accepted file byte; queue a write per pixel.
    function void take_byte(logic [BYTE_W-1:0] b, logic first_flag);
      int unsigned row, col;
      fb_write_t   w;
      bytes_taken++;
      if (first_flag) begin
        hdr_pos    = '0;
        img_w      = '0;
        img_h      = '0;
        col_pos    = '0;
        file_row   = '0;
        bgr_phase  = '0;
        blue_green = '0;
        pad_left   = '0;
        hdr_shift  = '0;
        image_done = 1'b0;
      end
      if (image_done) return;

      if (hdr_pos < HDR_BYTES) begin
        hdr_shift = {b, hdr_shift[31:8]};
        if (hdr_pos == WIDTH_LAST_OFS) img_w = clamp_dim(hdr_shift);
        else if (hdr_pos == HEIGHT_LAST_OFS) img_h = clamp_dim(hdr_shift);
        hdr_pos++;
        if (hdr_pos == HDR_BYTES && (img_w == 0 || img_h == 0)) image_done = 1'b1;
        return;
      end

      if (pad_left != 0) begin
        pad_left--;
        return;
      end

      if (bgr_phase < 2) begin
        blue_green = {blue_green[7:0], b};
        bgr_phase++;
        return;
      end

      bgr_phase = '0;
      row    = origin_row + img_h - 32'd1 - file_row;
      col    = origin_col + col_pos;
      w.addr = ADDR_W'(row * FRAME_WIDTH_DEF + col);
      w.word = {blue_green, b};
      w.off  = (row >= FRAME_HEIGHT_DEF) || (col >= FRAME_WIDTH_DEF);
      w.last = (file_row + 32'd1 == img_h) && (col_pos + 32'd1 == img_w);
      pending_writes.push_back(w);

      col_pos++;
      if (col_pos >= img_w) begin
        col_pos  = '0;
        file_row++;
        pad_left = img_w[1:0];
      end
      if (w.last) image_done = 1'b1;
    endfunction

    task flag_mismatch(string msg);
      fail_count++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_write(fb_write_t got);
      fb_write_t want;
      writes_checked++;
      if (got.off === 1'b1) off_screen_seen++;
      if (got.last === 1'b1) images_done++;
      if (pending_writes.size() == 0) begin
        flag_mismatch($sformatf("write %0d at %h arrived with none pending",
                                writes_checked, got.addr));
        return;
      end
      want = pending_writes.pop_front();
      if (got.addr !== want.addr)
        flag_mismatch($sformatf("write %0d pixel_address %h, want %h",
                                writes_checked, got.addr, want.addr));
      if (got.word !== want.word)
        flag_mismatch($sformatf("write %0d pixel_word %h, want %h",
                                writes_checked, got.word, want.word));
      if (got.off !== want.off)
        flag_mismatch($sformatf("write %0d off_screen %b, want %b",
                                writes_checked, got.off, want.off));
      if (got.last !== want.last)
        flag_mismatch($sformatf("write %0d last_pixel %b, want %b",
                                writes_checked, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bfw_in_if  in_bus();
  bfw_out_if out_bus();
  bfw_cfg_if cfg_bus();

  bmp24_to_framebuffer_writer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  bmp_pixel_scoreboard sb = new();

  bit          gaps_on = 1'b1;     // random idle bursts on both sides
  bit          long_hold_req;      // ask the receiver for one long stall
  int unsigned bytes_sent;

  // Free-running clock, 4 ns period.
  always #2 clk = ~clk;

  // Note every accepted beat on each channel at the rising edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)
        sb.set_origin(cfg_bus.reg_index, cfg_bus.wr_data);
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        sb.take_byte(in_bus.file_byte, in_bus.first_byte);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        sb.check_write(fb_write_t'{out_bus.pixel_address, out_bus.pixel_word,
                                   out_bus.off_screen, out_bus.last_pixel});
    end
  end

  // Receiver: random stall bursts, plus one long hold on request so the
  // two pipeline stages fill and the block stops taking bytes.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
          stall_left = int'($urandom_range(1, 6));
        out_bus.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Offer one byte; enter and leave at a falling edge. Valid stays high
  // between back-to-back beats and drops only for an idle burst.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first_flag);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.file_byte  <= b;
    in_bus.first_byte <= first_flag;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stream one bitmap file: random header with the given dimension fields,
  // then pixel and pad bytes (constant when fill >= 0). Stop after cut_len
  // bytes when cut_len >= 0, cap oversized bodies, and append junk bytes.
  task automatic send_bitmap(input logic [31:0] width_field, input logic [31:0] height_field,
                             input int cut_len, input int junk, input int fill);
    logic [DIM_BITS_DEF-1:0] w, h;
    int                      keep;
    logic [BYTE_W-1:0]       b;
    w    = clamp_dim(width_field);
    h    = clamp_dim(height_field);
    keep = HDR_BYTES + int'(h) * (3 * int'(w) + int'(w[1:0]));
    if (cut_len >= 0 && cut_len < keep) keep = cut_len;
    if (keep > HDR_BYTES + MAX_BODY) keep = HDR_BYTES + int'($urandom_range(0, MAX_BODY));
    for (int i = 0; i < keep; i++) begin
      if (i >= 18 && i < 22) b = width_field[8*(i-18) +: 8];
      else if (i >= 22 && i < 26) b = height_field[8*(i-22) +: 8];
      else if (i >= HDR_BYTES && fill >= 0) b = fill[BYTE_W-1:0];
      else b = BYTE_W'($urandom_range(0, 255));
      send_byte(b, i == 0);
    end
    repeat (junk) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
  endtask

  // Random file: mostly small well-formed images, sometimes raw 32-bit
  // dimensions (negative or saturating), sometimes cut short.
  task automatic random_bitmap();
    logic [31:0] wf, hf;
    int          cut_len;
    if ($urandom_range(0, 5) == 0) begin
      wf = $urandom;
      hf = $urandom;
    end else begin
      wf = $urandom_range(0, 9);
      hf = $urandom_range(0, 5);
      if (wf == 0 && $urandom_range(0, 1) == 0) wf = 1;
    end
    cut_len = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 200)) : -1;
    send_bitmap(wf, hf, cut_len,
                ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0, -1);
  endtask

  // Drop valid and wait until every predicted write is out, then let the
  // pipeline empty before touching the registers.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_origin(input logic [CFG_DATA_W-1:0] row_val,
                              input logic [CFG_DATA_W-1:0] col_val);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= REG_ORIGIN_ROW;
    cfg_bus.wr_data   <= row_val;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_bus.reg_index <= REG_ORIGIN_COLUMN;
    cfg_bus.wr_data   <= col_val;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Main sequence: reset, directed files, then random phases.
  initial begin
    int unsigned rand_start;
    int          wait_cycles;
    in_bus.valid      = 1'b0;
    in_bus.file_byte  = '0;
    in_bus.first_byte = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = REG_ORIGIN_ROW;
    cfg_bus.wr_data   = '0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Stray bytes before any file start: all dropped.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    // 2x2 all-white image with two pad bytes per row; junk after the end.
    send_bitmap(32'd2, 32'd2, -1, 3, 8'hFF);
    // 3x1 all-black image, three pad bytes.
    send_bitmap(32'd3, 32'd1, -1, 0, 8'h00);
    // Negative width reads as zero: header only, trailing bytes dropped.
    send_bitmap(32'hFFFF_FFFE, 32'd3, -1, 4, -1);
    // Zero height: nothing to write.
    send_bitmap(32'd5, 32'd0, -1, 2, -1);

    // Bottom-right corner: rows and columns spill past the frame.
    settle();
    write_origin(10'd479, 10'd639);
    send_bitmap(32'd2, 32'd3, -1, 0, -1);
    // Both dimensions saturate; three pixels, then the next file restarts
    // the parse mid-image. The first row lands far below the frame so the
    // address wraps at 20 bits.
    send_bitmap(32'h0001_0000, 32'h7FFF_FFFF, HDR_BYTES + 9, 0, -1);

    // Out-of-range register values: masked to the register widths.
    settle();
    write_origin(10'h3FF, 10'h3FF);
    send_bitmap(32'd1, 32'd1, -1, 1, -1);

    settle();
    write_origin(10'd0, 10'd0);
    send_bitmap(32'd4, 32'd1, -1, 0, -1);

    // Back-pressure: receiver holds off while bytes keep coming.
    settle();
    write_origin(10'd100, 10'd200);
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    send_bitmap(32'd8, 32'd6, -1, 0, -1);
    gaps_on = 1'b1;

    // Random phases: new origin while idle, then a few files each.
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      settle();
      case ($urandom_range(0, 5))
        0:       write_origin(10'd0, 10'd0);
        1:       write_origin(10'd479, 10'd639);
        2:       write_origin(CFG_DATA_W'($urandom_range(0, 1023)),
                              CFG_DATA_W'($urandom_range(0, 1023)));
        default: write_origin(CFG_DATA_W'($urandom_range(0, 479)),
                              CFG_DATA_W'($urandom_range(0, 639)));
      endcase
      // Run the closing stretch with no idling on either side.
      if (bytes_sent - rand_start >= RANDOM_BYTES - QUIET_BYTES) gaps_on = 1'b0;
      repeat ($urandom_range(2, 4)) random_bitmap();
    end

    // Drain, bounded; anything still pending is a missing write.
    in_bus.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_writes.size() != 0 && wait_cycles < END_WAIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (sb.pending_writes.size() != 0)
      sb.flag_mismatch($sformatf("%0d pixel writes never arrived", sb.pending_writes.size()));
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d file bytes, %0d register writes, %0d pixel writes checked",
             sb.bytes_taken, sb.reg_writes, sb.writes_checked);
    $display("  of which %0d off-frame, %0d images run to their last pixel",
             sb.off_screen_seen, sb.images_done);
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/bfw_pkg.sv
sv/bfw_if.sv
sv/bmp24_to_framebuffer_writer.sv
dv/bmp24_to_framebuffer_writer_tb.sv
